@@ hw/rtl/grid_bilinear_point_lookup_top_macros.svh @@
// Assertion macros for the bilinear grid point lookup block.
// Included by grid_bilinear_point_lookup_top.sv; no other dependencies.
`ifndef GRID_BILINEAR_POINT_LOOKUP_TOP_MACROS_SVH
`define GRID_BILINEAR_POINT_LOOKUP_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GBPL_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define GBPL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hw/rtl/gbpl_pkg.sv @@
// Shared types and codes for the bilinear grid point lookup block.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package gbpl_pkg;

   typedef logic        [4:0]  idx_type;    // node row / column, cell count
   typedef logic signed [31:0] coord_type;  // Q16.16
   typedef logic signed [22:0] uv_type;     // Q7.16
   typedef logic        [1:0]  csr_idx_type;
   typedef logic        [4:0]  csr_data_type;

   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   localparam logic STATUS_DONE  = 1'b0;
   localparam logic STATUS_RANGE = 1'b1;

   localparam csr_idx_type CSR_ROWS_IN_USE = 2'd0;
   localparam csr_idx_type CSR_COLS_IN_USE = 2'd1;

   localparam int FRAC_BITS = 16;

endpackage

`default_nettype wire

@@ hw/rtl/gbpl_if.sv @@
// Channel interfaces (request, response, register write) for the lookup block.
// Depends on gbpl_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface gbpl_req_if;
   import gbpl_pkg::*;
   logic      valid;
   logic      ready;
   logic      action;
   idx_type   node_row;
   idx_type   node_col;
   coord_type node_x;
   coord_type node_y;
   uv_type    coord_u;
   uv_type    coord_v;
   modport source (output valid, action, node_row, node_col, node_x, node_y,
                   coord_u, coord_v, input ready);
   modport sink   (input valid, action, node_row, node_col, node_x, node_y,
                   coord_u, coord_v, output ready);
endinterface

interface gbpl_rsp_if;
   import gbpl_pkg::*;
   logic      valid;
   logic      ready;
   logic      status;
   coord_type point_x;
   coord_type point_y;
   modport source (output valid, status, point_x, point_y, input ready);
   modport sink   (input valid, status, point_x, point_y, output ready);
endinterface

interface gbpl_csr_if;
   import gbpl_pkg::*;
   logic         valid;
   logic         ready;
   csr_idx_type  index;
   csr_data_type data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/grid_bilinear_point_lookup_top.sv @@
// Node write: write step, then finish step. In-range query: the four corners are fetched
// on the node memory's single read port, then 6 interpolations run as subtract, multiply
// and add steps on one shared unit; rejected query skips to finish. One transaction at a time.
// Reset: synchronous; a clearing pass over all (MAX_ROWS+1)*(MAX_COLS+1) node entries (1024 by
// default) zeroes the node memory, during which no request is taken; CSRs stay open.
// Depends on gbpl_pkg, gbpl_if and the assertion macro header.
`timescale 1ns / 1ps
`default_nettype none
`include "grid_bilinear_point_lookup_top_macros.svh"

module grid_bilinear_point_lookup_top #(
   parameter int MAX_ROWS = 31,
   parameter int MAX_COLS = 31
) (
   input  wire        clock,
   input  wire        reset,
   gbpl_req_if.sink   req_chan,
   gbpl_rsp_if.source rsp_chan,
   gbpl_csr_if.sink   csr_chan
);
   import gbpl_pkg::*;

   localparam int STRIDE = MAX_COLS + 1;
   localparam int DEPTH  = (MAX_ROWS + 1) * STRIDE;
   localparam int ADDR_W = $clog2(DEPTH);

   typedef enum logic [7:0] {
      S_CLEAR  = 8'b0000_0001,
      S_IDLE   = 8'b0000_0010,
      S_WRITE  = 8'b0000_0100,
      S_FETCH  = 8'b0000_1000,
      S_SUB    = 8'b0001_0000,
      S_MUL    = 8'b0010_0000,
      S_ADD    = 8'b0100_0000,
      S_FINISH = 8'b1000_0000
   } state_type;

   typedef logic [ADDR_W-1:0] addr_type;

   state_type state_ff, state_in;
   addr_type  clr_addr_ff, clr_addr_in;
   idx_type   rows_ff, rows_in, cols_ff, cols_in;

   logic        action_ff, action_in;
   logic        oor_ff, oor_in;
   addr_type    base_ff, base_in;
   logic [63:0] wd_ff, wd_in;
   logic [15:0] du_ff, du_in, dv_ff, dv_in;
   logic [2:0]  fcnt_ff, fcnt_in;
   logic [2:0]  step_ff, step_in;

   coord_type          corner_x_ff [4];
   coord_type          corner_y_ff [4];
   coord_type          lerp_ff     [6];
   logic signed [32:0] diff_ff;
   logic signed [49:0] prod_ff;

   logic      rsp_valid_ff, rsp_valid_in;
   logic      status_ff, status_in;
   coord_type point_x_ff, point_x_in, point_y_ff, point_y_in;

   logic [63:0] mem [DEPTH];
   logic [63:0] mem_rd_ff;
   logic        mem_we;
   addr_type    mem_wa, mem_ra;
   logic [63:0] mem_wd;

   logic              req_acc, out_free;
   logic signed [6:0] cell_j, cell_i;
   idx_type           row_sel, col_sel;
   logic              wr_oor, qry_oor;
   addr_type          corner_off;
   coord_type         op_a, op_b;
   logic [15:0]       op_f;
   logic signed [33:0] sum_w;

   // ---------------------------------------------------------------- handshakes
   assign req_chan.ready   = (state_ff == S_IDLE);
   assign req_acc          = req_chan.valid && req_chan.ready;
   assign csr_chan.ready   = 1'b1;
   assign out_free         = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.status  = status_ff;
   assign rsp_chan.point_x = point_x_ff;
   assign rsp_chan.point_y = point_y_ff;

   // ---------------------------------------------------------------- CSRs
   // unknown register indexes are ignored
   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_chan.valid) begin
         if (csr_chan.index == CSR_ROWS_IN_USE) begin
            rows_in = (32'(csr_chan.data) > MAX_ROWS) ? 5'(MAX_ROWS) : csr_chan.data;
         end else if (csr_chan.index == CSR_COLS_IN_USE) begin
            cols_in = (32'(csr_chan.data) > MAX_COLS) ? 5'(MAX_COLS) : csr_chan.data;
         end
      end
   end

   // ---------------------------------------------------------------- request decode
   assign cell_j  = req_chan.coord_u[22:16];
   assign cell_i  = req_chan.coord_v[22:16];
   assign wr_oor  = (req_chan.node_row > rows_ff) || (req_chan.node_col > cols_ff);
   assign qry_oor = cell_j[6] || cell_i[6] || (cell_i[5:0] >= {1'b0, rows_ff})
                    || (cell_j[5:0] >= {1'b0, cols_ff});
   assign row_sel = (req_chan.action == ACTION_WRITE) ? req_chan.node_row : cell_i[4:0];
   assign col_sel = (req_chan.action == ACTION_WRITE) ? req_chan.node_col : cell_j[4:0];

   // corner order: (i,j), (i,j+1), (i+1,j+1), (i+1,j)
   always_comb begin
      unique case (fcnt_ff[1:0])
         2'd0:    corner_off = '0;
         2'd1:    corner_off = ADDR_W'(1);
         2'd2:    corner_off = ADDR_W'(STRIDE + 1);
         2'd3:    corner_off = ADDR_W'(STRIDE);
         default: corner_off = '0;
      endcase
   end

   // ---------------------------------------------------------------- shared lerp unit
   always_comb begin
      op_a = lerp_ff[0];
      op_b = lerp_ff[2];
      op_f = dv_ff;
      unique case (step_ff)
         3'd0: begin op_a = corner_x_ff[0]; op_b = corner_x_ff[1]; op_f = du_ff; end
         3'd1: begin op_a = corner_y_ff[0]; op_b = corner_y_ff[1]; op_f = du_ff; end
         3'd2: begin op_a = corner_x_ff[3]; op_b = corner_x_ff[2]; op_f = du_ff; end
         3'd3: begin op_a = corner_y_ff[3]; op_b = corner_y_ff[2]; op_f = du_ff; end
         3'd4: begin op_a = lerp_ff[0];     op_b = lerp_ff[2];     op_f = dv_ff; end
         3'd5: begin op_a = lerp_ff[1];     op_b = lerp_ff[3];     op_f = dv_ff; end
         default: begin op_a = lerp_ff[0]; op_b = lerp_ff[2]; op_f = dv_ff; end
      endcase
   end

   // floor of the product by the arithmetic shift, then back onto the start point
   assign sum_w = 34'(op_a) + prod_ff[49:FRAC_BITS];

   // ---------------------------------------------------------------- sequencer
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      action_in    = action_ff;
      oor_in       = oor_ff;
      base_in      = base_ff;
      wd_in        = wd_ff;
      du_in        = du_ff;
      dv_in        = dv_ff;
      fcnt_in      = fcnt_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      status_in    = status_ff;
      point_x_in   = point_x_ff;
      point_y_in   = point_y_ff;
      mem_we       = 1'b0;
      mem_wa       = base_ff;
      mem_wd       = wd_ff;
      mem_ra       = base_ff + corner_off;

      unique case (state_ff)
         S_CLEAR: begin
            mem_we      = 1'b1;
            mem_wa      = clr_addr_ff;
            mem_wd      = '0;
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_acc) begin
               action_in = req_chan.action;
               base_in   = ADDR_W'(32'(row_sel) * STRIDE + 32'(col_sel));
               wd_in     = {req_chan.node_x, req_chan.node_y};
               du_in     = req_chan.coord_u[15:0];
               dv_in     = req_chan.coord_v[15:0];
               fcnt_in   = '0;
               step_in   = '0;
               if (req_chan.action == ACTION_WRITE) begin
                  oor_in   = wr_oor;
                  state_in = S_WRITE;
               end else begin
                  oor_in   = qry_oor;
                  state_in = qry_oor ? S_FINISH : S_FETCH;
               end
            end
         end
         S_WRITE: begin
            mem_we   = !oor_ff;
            state_in = S_FINISH;
         end
         S_FETCH: begin
            fcnt_in = fcnt_ff + 3'd1;
            if (fcnt_ff == 3'd4) begin
               state_in = S_SUB;
            end
         end
         S_SUB: begin
            state_in = S_MUL;
         end
         S_MUL: begin
            state_in = S_ADD;
         end
         S_ADD: begin
            step_in  = step_ff + 3'd1;
            state_in = (step_ff == 3'd5) ? S_FINISH : S_SUB;
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               status_in    = oor_ff ? STATUS_RANGE : STATUS_DONE;
               if (action_ff == ACTION_QUERY && !oor_ff) begin
                  point_x_in = lerp_ff[4];
                  point_y_in = lerp_ff[5];
               end else begin
                  point_x_in = '0;
                  point_y_in = '0;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_addr_ff  <= '0;
         rows_ff      <= 5'd1;
         cols_ff      <= 5'd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         rows_ff      <= rows_in;
         cols_ff      <= cols_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      action_ff  <= action_in;
      oor_ff     <= oor_in;
      base_ff    <= base_in;
      wd_ff      <= wd_in;
      du_ff      <= du_in;
      dv_ff      <= dv_in;
      fcnt_ff    <= fcnt_in;
      step_ff    <= step_in;
      status_ff  <= status_in;
      point_x_ff <= point_x_in;
      point_y_ff <= point_y_in;
      // read data arrives in the cycle after its address
      if (state_ff == S_FETCH && fcnt_ff != 3'd0) begin
         corner_x_ff[2'(fcnt_ff - 3'd1)] <= mem_rd_ff[63:32];
         corner_y_ff[2'(fcnt_ff - 3'd1)] <= mem_rd_ff[31:0];
      end
      if (state_ff == S_SUB) begin
         diff_ff <= 33'(op_b) - 33'(op_a);
      end
      if (state_ff == S_MUL) begin
         prod_ff <= 50'(diff_ff) * 50'($signed({1'b0, op_f}));
      end
      if (state_ff == S_ADD) begin
         lerp_ff[step_ff] <= sum_w[31:0];
      end
   end

   // node memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= mem[mem_ra];
   end

   // ---------------------------------------------------------------- assertions
   `GBPL_ASSERT_SAME(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == S_FINISH, "response raised outside the finish step")
   `GBPL_ASSERT_SAME(a_no_write_oor, clock, reset, mem_we && state_ff != S_CLEAR,
      !oor_ff && action_ff == ACTION_WRITE, "node memory written by a rejected item")
   `GBPL_ASSERT_SAME(a_reject_zero, clock, reset, rsp_valid_ff && status_ff == STATUS_RANGE,
      point_x_ff == '0 && point_y_ff == '0, "rejected transaction carries a point")
   `GBPL_ASSERT_NEXT(a_add_to_next, clock, reset, state_ff == S_ADD && step_ff != 3'd5,
      state_ff == S_SUB && step_ff == $past(step_ff) + 3'd1, "lerp step sequence broken")

endmodule

`default_nettype wire

@@ dv/tb_grid_bilinear_point_lookup_top.sv @@
// Self-checking testbench for grid_bilinear_point_lookup_top: node writes and bilinear
// queries are predicted in-bench and every response is compared in arrival order.
// Depends on gbpl_pkg, gbpl_if and the RTL top level.
`timescale 1ns / 1ps

module tb_grid_bilinear_point_lookup_top;
   import gbpl_pkg::*;

   localparam int GRID_MAX_ROWS = 31;
   localparam int GRID_MAX_COLS = 31;

   typedef struct {
      logic      action;
      idx_type   row;
      idx_type   col;
      coord_type x;
      coord_type y;
      uv_type    u;
      uv_type    v;
   } grid_op_type;

   typedef struct {
      logic      status;
      coord_type point_x;
      coord_type point_y;
   } grid_result_type;

   logic clock;
   logic reset;

   gbpl_req_if req_if ();
   gbpl_rsp_if rsp_if ();
   gbpl_csr_if csr_if ();

   grid_bilinear_point_lookup_top #(
      .MAX_ROWS (GRID_MAX_ROWS),
      .MAX_COLS (GRID_MAX_COLS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // shadow of the node memory and grid size
   coord_type node_x_mem [0:GRID_MAX_ROWS][0:GRID_MAX_COLS];
   coord_type node_y_mem [0:GRID_MAX_ROWS][0:GRID_MAX_COLS];
   int        rows_used;
   int        cols_used;

   grid_result_type expected_points [$];
   int              mismatch_count;
   bit              steady_flow;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("tb_grid_bilinear_point_lookup_top: done, errors");
      $finish;
   end

   // one interpolation step, product floored by arithmetic shift
   function automatic longint blend16(longint a, longint b, longint frac);
      return a + (((b - a) * frac) >>> FRAC_BITS);
   endfunction

   function automatic grid_result_type predict_lookup(grid_op_type op);
      grid_result_type res;
      longint          u, v, ci, cj, du, dv, ax, ay, bx, by, rx, ry;
      res.status  = STATUS_DONE;
      res.point_x = '0;
      res.point_y = '0;
      if (op.action == ACTION_WRITE) begin
         if (int'(op.row) > rows_used || int'(op.col) > cols_used) begin
            res.status = STATUS_RANGE;
         end else begin
            node_x_mem[op.row][op.col] = op.x;
            node_y_mem[op.row][op.col] = op.y;
         end
      end else begin
         u  = op.u;
         v  = op.v;
         cj = u >>> FRAC_BITS;
         ci = v >>> FRAC_BITS;
         if (ci < 0 || cj < 0 || ci >= rows_used || cj >= cols_used) begin
            res.status = STATUS_RANGE;
         end else begin
            du = longint'(op.u[15:0]);
            dv = longint'(op.v[15:0]);
            ax = blend16(node_x_mem[ci][cj], node_x_mem[ci][cj + 1], du);
            ay = blend16(node_y_mem[ci][cj], node_y_mem[ci][cj + 1], du);
            bx = blend16(node_x_mem[ci + 1][cj], node_x_mem[ci + 1][cj + 1], du);
            by = blend16(node_y_mem[ci + 1][cj], node_y_mem[ci + 1][cj + 1], du);
            rx = blend16(ax, bx, dv);
            ry = blend16(ay, by, dv);
            res.point_x = rx[31:0];
            res.point_y = ry[31:0];
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(string msg);
      mismatch_count++;
      if (mismatch_count <= 10) $display("%0t ns: %s", $time, msg);
   endtask

   // response checker
   always @(posedge clock) begin : point_check
      grid_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_points.size() == 0) begin
            report_mismatch("response transaction with nothing outstanding");
         end else begin
            want = expected_points.pop_front();
            if (rsp_if.status !== want.status || rsp_if.point_x !== want.point_x ||
                rsp_if.point_y !== want.point_y)
               report_mismatch($sformatf(
                  "expected status %0d x %0d y %0d, got status %0d x %0d y %0d",
                  want.status, want.point_x, want.point_y,
                  rsp_if.status, rsp_if.point_x, rsp_if.point_y));
         end
      end
   end

   always @(negedge clock) begin
      rsp_if.ready <= steady_flow || ($urandom_range(99) >= 20);
   end

   task automatic send_op(grid_op_type op);
      @(negedge clock);
      while (!steady_flow && $urandom_range(99) < 20) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid    = 1'b1;
      req_if.action   = op.action;
      req_if.node_row = op.row;
      req_if.node_col = op.col;
      req_if.node_x   = op.x;
      req_if.node_y   = op.y;
      req_if.coord_u  = op.u;
      req_if.coord_v  = op.v;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      expected_points.insert(expected_points.size(), predict_lookup(op));
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(csr_idx_type idx, csr_data_type val);
      @(negedge clock);
      csr_if.valid = 1'b1;
      csr_if.index = idx;
      csr_if.data  = val;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      if (idx == CSR_ROWS_IN_USE)
         rows_used = (int'(val) > GRID_MAX_ROWS) ? GRID_MAX_ROWS : int'(val);
      else if (idx == CSR_COLS_IN_USE)
         cols_used = (int'(val) > GRID_MAX_COLS) ? GRID_MAX_COLS : int'(val);
      @(negedge clock);
      csr_if.valid = 1'b0;
   endtask

   // unused fields carry random junk
   function automatic grid_op_type make_write(int row, int col, coord_type x, coord_type y);
      grid_op_type op;
      op.action = ACTION_WRITE;
      op.row    = idx_type'(row);
      op.col    = idx_type'(col);
      op.x      = x;
      op.y      = y;
      op.u      = uv_type'($urandom);
      op.v      = uv_type'($urandom);
      return op;
   endfunction

   function automatic grid_op_type make_query(int u, int v);
      grid_op_type op;
      op.action = ACTION_QUERY;
      op.row    = idx_type'($urandom);
      op.col    = idx_type'($urandom);
      op.x      = coord_type'($urandom);
      op.y      = coord_type'($urandom);
      op.u      = uv_type'(u);
      op.v      = uv_type'(v);
      return op;
   endfunction

   // mostly in-grid queries and writes, the rest anywhere
   function automatic grid_op_type random_op();
      grid_op_type op;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 60 && rows_used > 0 && cols_used > 0)
         op = make_query($urandom_range(cols_used - 1) * 65536 + $urandom_range(65535),
                         $urandom_range(rows_used - 1) * 65536 + $urandom_range(65535));
      else if (pick < 85)
         op = make_write($urandom_range(rows_used), $urandom_range(cols_used),
                         coord_type'($urandom), coord_type'($urandom));
      else if (pick < 92)
         op = make_write($urandom, $urandom, coord_type'($urandom), coord_type'($urandom));
      else
         op = make_query($urandom, $urandom);
      return op;
   endfunction

   task automatic test_cleared_store();
      send_op(make_query(32'h8000, 32'h8000));
      send_op(make_query(0, 0));
   endtask

   task automatic test_unit_cell();
      send_op(make_write(0, 0, 32'h7fffffff, 32'h80000000));
      send_op(make_write(0, 1, 32'h80000000, 32'h7fffffff));
      send_op(make_write(1, 0, 32'h12345678, 32'hffffffff));
      send_op(make_write(1, 1, -32'sh07654321, 32'h7fffffff));
      send_op(make_query(0, 0));
      send_op(make_query(32'hffff, 32'hffff));
      send_op(make_query(32'h8000, 32'h4000));
      send_op(make_query(32'h10000, 0));     // column one past the grid
      send_op(make_query(0, -1));            // row floors to -1
      send_op(make_query(4194303, 4194303));
      send_op(make_query(-4194304, -4194304));
      send_op(make_write(2, 0, 32'h1, 32'h1));
      send_op(make_write(0, 2, 32'h1, 32'h1));
   endtask

   task automatic test_zero_size();
      wait_idle();
      write_csr(CSR_ROWS_IN_USE, 5'd0);
      write_csr(CSR_COLS_IN_USE, 5'd0);
      send_op(make_query(0, 0));
      send_op(make_write(0, 0, 32'h00010000, -32'sh00020000));
      send_op(make_write(0, 1, 32'h1, 32'h1));
   endtask

   task automatic test_full_size();
      wait_idle();
      write_csr(CSR_ROWS_IN_USE, 5'd31);
      write_csr(CSR_COLS_IN_USE, 5'd31);
      send_op(make_write(31, 31, 32'h7fffffff, 32'h7fffffff));
      send_op(make_write(30, 30, 32'h80000000, 32'h00000000));
      send_op(make_write(30, 31, 32'h00abcdef, 32'h80000000));
      send_op(make_write(31, 30, -32'sh00123456, 32'h40000000));
      send_op(make_query(30 * 65536 + 32'h9abc, 30 * 65536 + 32'h3def));
      send_op(make_query(31 * 65536, 0));
   endtask

   task automatic run_random_phase(csr_data_type rows, csr_data_type cols, int count,
                                   bit flow);
      wait_idle();
      write_csr(CSR_ROWS_IN_USE, rows);
      write_csr(CSR_COLS_IN_USE, cols);
      steady_flow = flow;
      repeat (count) send_op(random_op());
      wait_idle();
      steady_flow = 1'b0;
   endtask

   task automatic test_random();
      run_random_phase(5'd1, 5'd1, 60, 1'b0);
      run_random_phase(5'd31, 5'd31, 90, 1'b0);
      run_random_phase(5'd4, 5'd6, 90, 1'b1);
      repeat (3)
         run_random_phase(csr_data_type'($urandom_range(1, 31)),
                          csr_data_type'($urandom_range(1, 31)), 90, 1'b0);
   endtask

   initial begin : main_seq
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.action  = ACTION_WRITE;
      req_if.node_row = '0;
      req_if.node_col = '0;
      req_if.node_x  = '0;
      req_if.node_y  = '0;
      req_if.coord_u = '0;
      req_if.coord_v = '0;
      rsp_if.ready   = 1'b0;
      csr_if.valid   = 1'b0;
      csr_if.index   = CSR_ROWS_IN_USE;
      csr_if.data    = '0;
      steady_flow    = 1'b0;
      mismatch_count = 0;
      rows_used      = 1;
      cols_used      = 1;
      for (int r = 0; r <= GRID_MAX_ROWS; r++) begin
         for (int c = 0; c <= GRID_MAX_COLS; c++) begin
            node_x_mem[r][c] = '0;
            node_y_mem[r][c] = '0;
         end
      end

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_cleared_store();
      test_unit_cell();
      test_zero_size();
      test_full_size();
      test_random();

      wait_idle();
      repeat (50) @(posedge clock);
      if (expected_points.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", expected_points.size()));

      if (mismatch_count == 0) begin
         $display("tb_grid_bilinear_point_lookup_top: done, clean");
      end else begin
         $display("tb_grid_bilinear_point_lookup_top: done, errors");
      end
      $finish;
   end

endmodule
